/* rtl/pva_pkg.sv */
// Shared constants and controller/datapath interface types for the voice allocator.
package pva_pkg;

    localparam int MAX_LANES_DEF = 16;
    localparam int KEY_W         = 7;
    localparam int LEVEL_W       = 7;
    localparam int STAMP_W       = 48;
    localparam int LANE_OUT_W    = 4;
    localparam int CFG_W         = 5;
    localparam int ENTRY_W       = KEY_W + STAMP_W;

    localparam logic [CFG_W-1:0] VOICE_LIMIT_RST = 5'd8;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // input beat accepted
        logic scan_rd;   // read lane entry at scan index
        logic emit_off;  // steal note-off beat
        logic emit_on;   // note-on beat, claims lane
        logic emit_rel;  // release beat if a match was found
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic free_found; // free lane below the limit
        logic on;         // captured event is a note-on
        logic scan_last;  // scan index at its final lane
    } t_status;

endpackage

/* rtl/pva_ctrl.sv */
// Sequencer for the voice allocator: accept, lane scan, result emission.
module pva_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_note_on,
    input  pva_pkg::t_status  i_status,
    output pva_pkg::t_cmd     o_cmd,
    output logic              busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_STEAL = 3'd3;
    localparam logic [2:0] S_ON    = 3'd4;
    localparam logic [2:0] S_REL   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    if (i_note_on && i_status.free_found) begin
                        n_state = S_ON;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last read lands in the compare this cycle
            S_DRAIN: begin
                n_state = i_status.on ? S_STEAL : S_REL;
            end
            S_STEAL: begin
                o_cmd.emit_off = 1'b1;
                n_state = S_ON;
            end
            S_ON: begin
                o_cmd.emit_on = 1'b1;
                n_state = S_IDLE;
            end
            S_REL: begin
                o_cmd.emit_rel = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_steal_then_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_off |=> o_cmd.emit_on)
        else $error("steal note-off not followed by note-on");

    a_scan_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture && !(i_note_on && i_status.free_found) |=> o_cmd.scan_rd)
        else $error("scan did not start after accept");
`endif

endmodule

/* rtl/pva_datapath.sv */
// Lane state, lane memory scan, best-lane compare and result registers.
module pva_datapath #(
    parameter int MAX_LANES = pva_pkg::MAX_LANES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pva_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  logic                              i_note_on,
    input  logic [pva_pkg::KEY_W-1:0]         i_key,
    input  logic [pva_pkg::LEVEL_W-1:0]       i_strike_level,
    input  logic [pva_pkg::STAMP_W-1:0]       i_stamp,
    input  pva_pkg::t_cmd                     i_cmd,
    output pva_pkg::t_status                  o_status,
    output logic                              o_valid,
    output logic [pva_pkg::LANE_OUT_W-1:0]    o_lane,
    output logic                              o_out_note_on,
    output logic [pva_pkg::KEY_W-1:0]         o_out_key,
    output logic [pva_pkg::LEVEL_W-1:0]       o_out_level,
    output logic [pva_pkg::STAMP_W-1:0]       o_out_stamp,
    output logic                              o_last
);

    localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int CW = $clog2(MAX_LANES + 1);
    localparam int EW = (CW > pva_pkg::CFG_W) ? CW : pva_pkg::CFG_W;

    logic [pva_pkg::CFG_W-1:0]   r_voice_limit;
    logic [MAX_LANES-1:0]        r_busy;
    logic [pva_pkg::ENTRY_W-1:0] mem [MAX_LANES];

    logic                        r_on;
    logic [pva_pkg::KEY_W-1:0]   r_key;
    logic [pva_pkg::LEVEL_W-1:0] r_level;
    logic [pva_pkg::STAMP_W-1:0] r_stamp;

    logic [LW-1:0]               r_idx;
    logic [LW-1:0]               r_rd_idx;
    logic                        r_rd_vld;
    logic [pva_pkg::ENTRY_W-1:0] r_rd_data;

    logic                        r_found;
    logic [LW-1:0]               r_pick;
    logic [pva_pkg::KEY_W-1:0]   r_best_key;
    logic [pva_pkg::STAMP_W-1:0] r_best_start;

    logic                          r_out_vld;
    logic [LW-1:0]                 r_out_lane;
    logic                          r_out_on;
    logic [pva_pkg::KEY_W-1:0]     r_out_key;
    logic [pva_pkg::LEVEL_W-1:0]   r_out_level;
    logic [pva_pkg::STAMP_W-1:0]   r_out_stamp;
    logic                          r_out_last;

    logic [EW-1:0]               limit_ext;
    logic [CW-1:0]               eff_limit;
    logic [LW-1:0]               scan_end;
    logic                        free_found;
    logic [LW-1:0]               free_idx;
    logic [pva_pkg::KEY_W-1:0]   rd_key;
    logic [pva_pkg::STAMP_W-1:0] rd_start;
    logic                        cand;
    logic                        take;

    // limit of zero acts as one, above MAX_LANES saturates
    assign limit_ext = EW'(r_voice_limit);
    always_comb begin
        if (limit_ext == '0) begin
            eff_limit = CW'(1);
        end else if (limit_ext > EW'(MAX_LANES)) begin
            eff_limit = CW'(MAX_LANES);
        end else begin
            eff_limit = CW'(limit_ext);
        end
    end

    // steal scans lanes under the limit, release scans every lane
    assign scan_end = r_on ? LW'(eff_limit - CW'(1)) : LW'(MAX_LANES - 1);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_LANES - 1; i >= 0; i--) begin
            if (!r_busy[i] && (CW'(i) < eff_limit)) begin
                free_found = 1'b1;
                free_idx   = LW'(i);
            end
        end
    end

    assign o_status.free_found = free_found;
    assign o_status.on         = r_on;
    assign o_status.scan_last  = (r_idx == scan_end);

    assign rd_key   = r_rd_data[pva_pkg::ENTRY_W-1 -: pva_pkg::KEY_W];
    assign rd_start = r_rd_data[pva_pkg::STAMP_W-1:0];

    // strict less-than keeps the lowest lane on equal starts
    assign cand = r_on ? 1'b1 : (r_busy[r_rd_idx] && (rd_key == r_key));
    assign take = r_rd_vld && cand && (!r_found || (rd_start < r_best_start));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_limit <= pva_pkg::VOICE_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_voice_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_on    <= i_note_on;
            r_key   <= i_key;
            r_level <= i_strike_level;
            r_stamp <= i_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.capture) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx  <= '0;
            r_pick <= free_idx;
        end else begin
            if (i_cmd.scan_rd) begin
                r_idx <= r_idx + LW'(1);
            end
            if (take) begin
                r_pick       <= r_rd_idx;
                r_best_key   <= rd_key;
                r_best_start <= rd_start;
            end
        end
        r_rd_idx <= r_idx;
    end

    // lane memory: key and start stamp, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_on) begin
            mem[r_pick] <= {r_key, r_stamp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_data <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_cmd.emit_on) begin
            r_busy[r_pick] <= 1'b1;
        end else if (i_cmd.emit_rel && r_found) begin
            r_busy[r_pick] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit_off || i_cmd.emit_on || (i_cmd.emit_rel && r_found);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_off) begin
            r_out_lane  <= r_pick;
            r_out_on    <= 1'b0;
            r_out_key   <= r_best_key;
            r_out_level <= '0;
            r_out_stamp <= r_stamp;
            r_out_last  <= 1'b0;
        end else if (i_cmd.emit_on || i_cmd.emit_rel) begin
            r_out_lane  <= r_pick;
            r_out_on    <= i_cmd.emit_on;
            r_out_key   <= r_key;
            r_out_level <= r_level;
            r_out_stamp <= r_stamp;
            r_out_last  <= 1'b1;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_lane        = pva_pkg::LANE_OUT_W'(r_out_lane);
    assign o_out_note_on = r_out_on;
    assign o_out_key     = r_out_key;
    assign o_out_level   = r_out_level;
    assign o_out_stamp   = r_out_stamp;
    assign o_last        = r_out_last;

`ifndef SYNTHESIS
    a_on_claims_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_on |=> r_busy[$past(r_pick)])
        else $error("note-on did not mark its lane busy");

    a_rel_frees_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_rel && r_found |=> !r_busy[$past(r_pick)])
        else $error("release did not free its lane");

    a_steal_same_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_last |=> r_out_vld && r_out_on && (r_out_lane == $past(r_out_lane)))
        else $error("steal note-off and note-on differ in lane");
`endif

endmodule

/* rtl/polyphonic_voice_allocator_unit.sv */
// Top level of the voice allocator: sequencer plus lane datapath.
// Free-lane note-on: the accept goes straight to the note-on beat, and the result is registered from it.
// Steal: busy through a scan of L lanes (L = effective limit); note-off then note-on back to back.
// Note-off: busy through a scan of all MAX_LANES lanes; zero or one result.
// Scan length is set by the single read port of the lane memory, one lane per cycle.
// Synchronous active-low reset frees all lanes and sets the limit to 8; results cannot be stalled.
module polyphonic_voice_allocator_unit #(
    parameter int MAX_LANES = pva_pkg::MAX_LANES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pva_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_note_on,
    input  logic [pva_pkg::KEY_W-1:0]         i_key,
    input  logic [pva_pkg::LEVEL_W-1:0]       i_strike_level,
    input  logic [pva_pkg::STAMP_W-1:0]       i_stamp,
    output logic                              o_valid,
    output logic [pva_pkg::LANE_OUT_W-1:0]    o_lane,
    output logic                              o_out_note_on,
    output logic [pva_pkg::KEY_W-1:0]         o_out_key,
    output logic [pva_pkg::LEVEL_W-1:0]       o_out_level,
    output logic [pva_pkg::STAMP_W-1:0]       o_out_stamp,
    output logic                              o_last
);

    pva_pkg::t_cmd    cmd;
    pva_pkg::t_status status;

    pva_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_note_on (i_note_on),
        .i_status  (status),
        .o_cmd     (cmd),
        .busy      (busy)
    );

    pva_datapath #(
        .MAX_LANES (MAX_LANES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_note_on      (i_note_on),
        .i_key          (i_key),
        .i_strike_level (i_strike_level),
        .i_stamp        (i_stamp),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_lane         (o_lane),
        .o_out_note_on  (o_out_note_on),
        .o_out_key      (o_out_key),
        .o_out_level    (o_out_level),
        .o_out_stamp    (o_out_stamp),
        .o_last         (o_last)
    );

endmodule
